@@ design/bpcr_pkg.sv @@
`default_nettype none

package bpcr_pkg;

    // field widths
    localparam int CW    = 24;          // coordinate, signed
    localparam int RW    = CW - 4;      // radius, unsigned
    localparam int EW    = 17;          // elasticity, unsigned q1.16
    localparam int NB    = 16;          // normal fraction bits
    localparam int XB    = 4;           // extra distance fraction bits

    localparam logic [EW-1:0] ELAST_RST = EW'(58982);
    localparam int            ELAST_ONE = 65536;

    // datapath widths
    localparam int DW    = CW + 1;              // centre difference
    localparam int MW    = RW + 1;              // radius sum
    localparam int SW    = 2 * MW;              // square of a radius sum
    localparam int VW    = SW + 2 * XB;         // square root operand
    localparam int SQN   = VW / 2;              // root bits, one per stage
    localparam int RTW   = SQN;                 // root width
    localparam int REMW  = SQN + 3;             // root remainder
    localparam int QW    = NB + 1;              // normal magnitude bits
    localparam int NUMW  = MW + NB + XB + 1;    // divider numerator
    localparam int DREMW = RTW + 1;             // divider remainder
    localparam int NW    = QW + 1;              // signed normal
    localparam int OVW   = RTW + 1;             // signed overlap
    localparam int PCW   = OVW + NW;            // correction product
    localparam int RVW   = CW + 2;              // relative velocity
    localparam int PSW   = RVW + NW;            // velocity product
    localparam int SUMW  = PSW + 1;             // normal velocity sum
    localparam int VVW   = SUMW - NB;           // rounded normal velocity
    localparam int EKW   = EW + 2;              // 1 + elasticity, signed
    localparam int JPW   = VVW + 1 + EKW;       // impulse product
    localparam int JW    = JPW - EW + 1;        // rounded impulse
    localparam int IPW   = JW + NW;             // impulse per axis product

    localparam int IN_DW  = 8 * CW + 2 * RW;
    localparam int OUT_DW = 8 * CW;

    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_SEP  = 2'd1,
        OUT_RES  = 2'd2
    } t_outcome;

    // state carried down the pipeline with each item
    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] aox;
        logic signed [CW-1:0] aoy;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] box;
        logic signed [CW-1:0] boy;
        logic [MW-1:0]        md;
        logic [MW-1:0]        mdx;
        logic [MW-1:0]        mdy;
        logic                 dxn;
        logic                 dyn;
        logic                 hit;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic                 sep;
    } t_pay;

endpackage

`default_nettype wire

@@ design/ball_pair_collision_response_core.sv @@
`default_nettype none

// channel   | dir | handshake                         | payload
// s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | tdata: circle pair (232 bits)
// m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | tdata: 8 coords, tuser: outcome
// cfg       | in  | i_cfg_we                          | i_cfg_wdata: elasticity q1.16
//
// one item per cycle sustained while the output is not stalled
// most of the pipeline depth lies in the root unit and the normal dividers
// synchronous active-low reset clears all valid bits and loads elasticity 58982
// a stalled output freezes every stage at once; o_s_axis_tready drops with it
module ball_pair_collision_response_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // a_x, a_y, a_old_x, a_old_y, a_radius, b_x, b_y, b_old_x, b_old_y, b_radius
    input  wire  [bpcr_pkg::IN_DW-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire                         i_m_axis_tready,
    // new_a_x, new_a_y, new_a_old_x, new_a_old_y,
    // new_b_x, new_b_y, new_b_old_x, new_b_old_y
    output logic [bpcr_pkg::OUT_DW-1:0] o_m_axis_tdata,
    // outcome
    output logic [1:0]                  o_m_axis_tuser,
    input  wire                         i_cfg_we,
    input  wire  [bpcr_pkg::EW-1:0]     i_cfg_wdata
);
    import bpcr_pkg::*;

    localparam logic signed [63:0] CMAX64 = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] CMIN64 = -CMAX64 - 64'sd1;

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                  input int unsigned s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [63:0] v);
        logic signed [CW-1:0] r;
        if (v > CMAX64) begin
            r = CMAX64[CW-1:0];
        end else if (v < CMIN64) begin
            r = CMIN64[CW-1:0];
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    logic en;
    logic [EW-1:0] r_elast;

    // global advance: the output slot is free or being taken
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elast <= ELAST_RST;
        end else if (i_cfg_we) begin
            r_elast <= i_cfg_wdata;
        end
    end

    // stage 0: unpack, centre differences, radius sum
    logic                 r_s0_valid, n_s0_valid;
    t_pay                 r_s0_pay, n_s0_pay;
    logic signed [DW-1:0] r_s0_dx, r_s0_dy, n_s0_dx, n_s0_dy;

    always_comb begin
        n_s0_valid = i_s_axis_tvalid;
        n_s0_pay   = '0;
        n_s0_pay.ax  = i_s_axis_tdata[0*CW +: CW];
        n_s0_pay.ay  = i_s_axis_tdata[1*CW +: CW];
        n_s0_pay.aox = i_s_axis_tdata[2*CW +: CW];
        n_s0_pay.aoy = i_s_axis_tdata[3*CW +: CW];
        n_s0_pay.bx  = i_s_axis_tdata[4*CW + RW +: CW];
        n_s0_pay.by  = i_s_axis_tdata[5*CW + RW +: CW];
        n_s0_pay.box = i_s_axis_tdata[6*CW + RW +: CW];
        n_s0_pay.boy = i_s_axis_tdata[7*CW + RW +: CW];
        n_s0_pay.md  = MW'(i_s_axis_tdata[4*CW +: RW])
                     + MW'(i_s_axis_tdata[8*CW + RW +: RW]);
        n_s0_dx = DW'(n_s0_pay.bx) - DW'(n_s0_pay.ax);
        n_s0_dy = DW'(n_s0_pay.by) - DW'(n_s0_pay.ay);
    end

    // stage 1: magnitudes, box precheck, squares
    logic          r_s1_valid;
    t_pay          r_s1_pay, n_s1_pay;
    logic [SW-1:0] r_s1_sqx, r_s1_sqy, r_s1_sqm, n_s1_sqx, n_s1_sqy, n_s1_sqm;

    always_comb begin
        logic [DW-1:0] ax_m, ay_m;
        ax_m = r_s0_dx[DW-1] ? DW'(-r_s0_dx) : DW'(r_s0_dx);
        ay_m = r_s0_dy[DW-1] ? DW'(-r_s0_dy) : DW'(r_s0_dy);
        n_s1_pay     = r_s0_pay;
        n_s1_pay.dxn = r_s0_dx[DW-1];
        n_s1_pay.dyn = r_s0_dy[DW-1];
        n_s1_pay.mdx = ax_m[MW-1:0];
        n_s1_pay.mdy = ay_m[MW-1:0];
        n_s1_pay.hit = (ax_m < DW'(r_s0_pay.md)) && (ay_m < DW'(r_s0_pay.md));
        n_s1_sqx = SW'(n_s1_pay.mdx) * SW'(n_s1_pay.mdx);
        n_s1_sqy = SW'(n_s1_pay.mdy) * SW'(n_s1_pay.mdy);
        n_s1_sqm = SW'(r_s0_pay.md) * SW'(r_s0_pay.md);
    end

    // root unit: entry 0 takes d2 and the contact test, one root bit per stage
    logic              r_sq_valid [0:SQN];
    t_pay              r_sq_pay   [0:SQN];
    logic [VW-1:0]     r_sq_v     [0:SQN];
    logic [REMW-1:0]   r_sq_rem   [0:SQN];
    logic [RTW-1:0]    r_sq_root  [0:SQN];
    t_pay              n_sq_pay   [0:SQN];
    logic [REMW-1:0]   n_sq_rem   [0:SQN];
    logic [RTW-1:0]    n_sq_root  [0:SQN];
    logic [VW-1:0]     n_sq_v0;

    always_comb begin
        logic [SW:0]     d2;
        logic [REMW-1:0] rt, trial;
        d2 = (SW+1)'(r_s1_sqx) + (SW+1)'(r_s1_sqy);
        n_sq_pay[0]     = r_s1_pay;
        n_sq_pay[0].hit = r_s1_pay.hit && (d2 != '0) && (d2 < (SW+1)'(r_s1_sqm));
        n_sq_v0         = VW'(d2[SW-1:0]) << (2 * XB);
        n_sq_rem[0]     = '0;
        n_sq_root[0]    = '0;
        for (int k = 1; k <= SQN; k++) begin
            n_sq_pay[k] = r_sq_pay[k-1];
            rt    = {r_sq_rem[k-1][REMW-3:0], r_sq_v[k-1][VW-2*k+1 -: 2]};
            trial = REMW'({r_sq_root[k-1], 2'b01});
            if (rt >= trial) begin
                n_sq_rem[k]  = rt - trial;
                n_sq_root[k] = {r_sq_root[k-1][RTW-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = rt;
                n_sq_root[k] = {r_sq_root[k-1][RTW-2:0], 1'b0};
            end
        end
    end

    // normal dividers: |d| * 2^20 / distance rounded, one quotient bit per stage
    logic              r_dv_valid [0:QW];
    t_pay              r_dv_pay   [0:QW];
    logic [RTW-1:0]    r_dv_dist  [0:QW];
    logic [NUMW-1:0]   r_dv_numx  [0:QW];
    logic [NUMW-1:0]   r_dv_numy  [0:QW];
    logic [DREMW-1:0]  r_dv_rx    [0:QW];
    logic [DREMW-1:0]  r_dv_ry    [0:QW];
    logic [QW-1:0]     r_dv_qx    [0:QW];
    logic [QW-1:0]     r_dv_qy    [0:QW];
    logic [NUMW-1:0]   n_dv_numx0, n_dv_numy0;
    logic [DREMW-1:0]  n_dv_rx    [0:QW];
    logic [DREMW-1:0]  n_dv_ry    [0:QW];
    logic [QW-1:0]     n_dv_qx    [0:QW];
    logic [QW-1:0]     n_dv_qy    [0:QW];

    always_comb begin
        logic [RTW-1:0]   root_len;
        logic [DREMW-1:0] tx, ty, dv;
        root_len = r_sq_root[SQN];
        n_dv_numx0 = (NUMW'(r_sq_pay[SQN].mdx) << (NB + XB)) + NUMW'(root_len >> 1);
        n_dv_numy0 = (NUMW'(r_sq_pay[SQN].mdy) << (NB + XB)) + NUMW'(root_len >> 1);
        n_dv_rx[0] = DREMW'(n_dv_numx0 >> QW);
        n_dv_ry[0] = DREMW'(n_dv_numy0 >> QW);
        n_dv_qx[0] = '0;
        n_dv_qy[0] = '0;
        for (int k = 1; k <= QW; k++) begin
            dv = DREMW'(r_dv_dist[k-1]);
            tx = {r_dv_rx[k-1][DREMW-2:0], r_dv_numx[k-1][QW-k]};
            ty = {r_dv_ry[k-1][DREMW-2:0], r_dv_numy[k-1][QW-k]};
            if (tx >= dv) begin
                n_dv_rx[k] = tx - dv;
                n_dv_qx[k] = {r_dv_qx[k-1][QW-2:0], 1'b1};
            end else begin
                n_dv_rx[k] = tx;
                n_dv_qx[k] = {r_dv_qx[k-1][QW-2:0], 1'b0};
            end
            if (ty >= dv) begin
                n_dv_ry[k] = ty - dv;
                n_dv_qy[k] = {r_dv_qy[k-1][QW-2:0], 1'b1};
            end else begin
                n_dv_ry[k] = ty;
                n_dv_qy[k] = {r_dv_qy[k-1][QW-2:0], 1'b0};
            end
        end
    end

    // p0: signed normal, overlap times normal
    logic                  r_p0_valid;
    t_pay                  r_p0_pay, n_p0_pay;
    logic signed [PCW-1:0] r_p0_cx, r_p0_cy, n_p0_cx, n_p0_cy;

    always_comb begin
        logic signed [NW-1:0]  ux, uy;
        logic signed [OVW-1:0] ov;
        ux = $signed({1'b0, r_dv_qx[QW]});
        uy = $signed({1'b0, r_dv_qy[QW]});
        n_p0_pay    = r_dv_pay[QW];
        n_p0_pay.nx = r_dv_pay[QW].dxn ? -ux : ux;
        n_p0_pay.ny = r_dv_pay[QW].dyn ? -uy : uy;
        ov = $signed(OVW'({r_dv_pay[QW].md, XB'(0)})) - $signed(OVW'(r_dv_dist[QW]));
        n_p0_cx = PCW'(ov) * PCW'(n_p0_pay.nx);
        n_p0_cy = PCW'(ov) * PCW'(n_p0_pay.ny);
    end

    // p1: push centres apart
    logic r_p1_valid;
    t_pay r_p1_pay, n_p1_pay;

    always_comb begin
        logic signed [63:0] cx, cy;
        cx = rnd_sh(64'(r_p0_cx), NB + XB + 1);
        cy = rnd_sh(64'(r_p0_cy), NB + XB + 1);
        n_p1_pay = r_p0_pay;
        if (r_p0_pay.hit) begin
            n_p1_pay.ax = sat(64'(r_p0_pay.ax) - cx);
            n_p1_pay.ay = sat(64'(r_p0_pay.ay) - cy);
            n_p1_pay.bx = sat(64'(r_p0_pay.bx) + cx);
            n_p1_pay.by = sat(64'(r_p0_pay.by) + cy);
        end
    end

    // p2: relative velocity
    logic                  r_p2_valid;
    t_pay                  r_p2_pay;
    logic signed [RVW-1:0] r_p2_rvx, r_p2_rvy, n_p2_rvx, n_p2_rvy;

    always_comb begin
        n_p2_rvx = (RVW'(r_p1_pay.bx) - RVW'(r_p1_pay.box))
                 - (RVW'(r_p1_pay.ax) - RVW'(r_p1_pay.aox));
        n_p2_rvy = (RVW'(r_p1_pay.by) - RVW'(r_p1_pay.boy))
                 - (RVW'(r_p1_pay.ay) - RVW'(r_p1_pay.aoy));
    end

    // p3: velocity along normal, per axis
    logic                  r_p3_valid;
    t_pay                  r_p3_pay;
    logic signed [PSW-1:0] r_p3_px, r_p3_py, n_p3_px, n_p3_py;

    assign n_p3_px = PSW'(r_p2_rvx) * PSW'(r_p2_pay.nx);
    assign n_p3_py = PSW'(r_p2_rvy) * PSW'(r_p2_pay.ny);

    // p4: sum, separating test, rounding
    logic                  r_p4_valid;
    t_pay                  r_p4_pay, n_p4_pay;
    logic signed [VVW-1:0] r_p4_v, n_p4_v;

    always_comb begin
        logic signed [SUMW-1:0] s;
        s = SUMW'(r_p3_px) + SUMW'(r_p3_py);
        n_p4_pay     = r_p3_pay;
        n_p4_pay.sep = (s > 0);
        n_p4_v       = VVW'(rnd_sh(64'(s), NB));
    end

    // p5: impulse times (1 + elasticity)
    logic                  r_p5_valid;
    t_pay                  r_p5_pay;
    logic signed [JPW-1:0] r_p5_jp, n_p5_jp;

    always_comb begin
        logic [EKW-1:0] eku;
        eku     = EKW'(r_elast) + EKW'(ELAST_ONE);
        n_p5_jp = -(JPW'(r_p4_v)) * JPW'($signed(eku));
    end

    // p6: impulse rounding
    logic                 r_p6_valid;
    t_pay                 r_p6_pay;
    logic signed [JW-1:0] r_p6_j, n_p6_j;

    assign n_p6_j = JW'(rnd_sh(64'(r_p5_jp), EW));

    // p7: impulse per axis
    logic                  r_p7_valid;
    t_pay                  r_p7_pay;
    logic signed [IPW-1:0] r_p7_ix, r_p7_iy, n_p7_ix, n_p7_iy;

    assign n_p7_ix = IPW'(r_p6_j) * IPW'(r_p6_pay.nx);
    assign n_p7_iy = IPW'(r_p6_j) * IPW'(r_p6_pay.ny);

    // output register: rebuild previous positions, pick outcome
    logic     r_out_valid;
    t_pay     r_out_pay, n_out_pay;
    t_outcome r_out_oc, n_out_oc;

    always_comb begin
        logic signed [63:0] ix, iy;
        ix = rnd_sh(64'(r_p7_ix), NB);
        iy = rnd_sh(64'(r_p7_iy), NB);
        n_out_pay = r_p7_pay;
        n_out_oc  = OUT_NONE;
        if (r_p7_pay.hit && r_p7_pay.sep) begin
            n_out_oc = OUT_SEP;
        end else if (r_p7_pay.hit) begin
            n_out_oc = OUT_RES;
            n_out_pay.aox = sat(64'(r_p7_pay.aox) + ix);
            n_out_pay.aoy = sat(64'(r_p7_pay.aoy) + iy);
            n_out_pay.box = sat(64'(r_p7_pay.box) - ix);
            n_out_pay.boy = sat(64'(r_p7_pay.boy) - iy);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            for (int k = 0; k <= SQN; k++) begin
                r_sq_valid[k] <= 1'b0;
            end
            for (int k = 0; k <= QW; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
            r_p0_valid  <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_p3_valid  <= 1'b0;
            r_p4_valid  <= 1'b0;
            r_p5_valid  <= 1'b0;
            r_p6_valid  <= 1'b0;
            r_p7_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid    <= n_s0_valid;
            r_s1_valid    <= r_s0_valid;
            r_sq_valid[0] <= r_s1_valid;
            for (int k = 1; k <= SQN; k++) begin
                r_sq_valid[k] <= r_sq_valid[k-1];
            end
            r_dv_valid[0] <= r_sq_valid[SQN];
            for (int k = 1; k <= QW; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
            r_p0_valid  <= r_dv_valid[QW];
            r_p1_valid  <= r_p0_valid;
            r_p2_valid  <= r_p1_valid;
            r_p3_valid  <= r_p2_valid;
            r_p4_valid  <= r_p3_valid;
            r_p5_valid  <= r_p4_valid;
            r_p6_valid  <= r_p5_valid;
            r_p7_valid  <= r_p6_valid;
            r_out_valid <= r_p7_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_pay <= n_s0_pay;
            r_s0_dx  <= n_s0_dx;
            r_s0_dy  <= n_s0_dy;
            r_s1_pay <= n_s1_pay;
            r_s1_sqx <= n_s1_sqx;
            r_s1_sqy <= n_s1_sqy;
            r_s1_sqm <= n_s1_sqm;
            r_sq_v[0] <= n_sq_v0;
            for (int k = 1; k <= SQN; k++) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
            for (int k = 0; k <= SQN; k++) begin
                r_sq_pay[k]  <= n_sq_pay[k];
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
            end
            r_dv_pay[0]  <= r_sq_pay[SQN];
            r_dv_dist[0] <= r_sq_root[SQN];
            r_dv_numx[0] <= n_dv_numx0;
            r_dv_numy[0] <= n_dv_numy0;
            for (int k = 1; k <= QW; k++) begin
                r_dv_pay[k]  <= r_dv_pay[k-1];
                r_dv_dist[k] <= r_dv_dist[k-1];
                r_dv_numx[k] <= r_dv_numx[k-1];
                r_dv_numy[k] <= r_dv_numy[k-1];
            end
            for (int k = 0; k <= QW; k++) begin
                r_dv_rx[k] <= n_dv_rx[k];
                r_dv_ry[k] <= n_dv_ry[k];
                r_dv_qx[k] <= n_dv_qx[k];
                r_dv_qy[k] <= n_dv_qy[k];
            end
            r_p0_pay  <= n_p0_pay;
            r_p0_cx   <= n_p0_cx;
            r_p0_cy   <= n_p0_cy;
            r_p1_pay  <= n_p1_pay;
            r_p2_pay  <= r_p1_pay;
            r_p2_rvx  <= n_p2_rvx;
            r_p2_rvy  <= n_p2_rvy;
            r_p3_pay  <= r_p2_pay;
            r_p3_px   <= n_p3_px;
            r_p3_py   <= n_p3_py;
            r_p4_pay  <= n_p4_pay;
            r_p4_v    <= n_p4_v;
            r_p5_pay  <= r_p4_pay;
            r_p5_jp   <= n_p5_jp;
            r_p6_pay  <= r_p5_pay;
            r_p6_j    <= n_p6_j;
            r_p7_pay  <= r_p6_pay;
            r_p7_ix   <= n_p7_ix;
            r_p7_iy   <= n_p7_iy;
            r_out_pay <= n_out_pay;
            r_out_oc  <= n_out_oc;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_pay.boy, r_out_pay.box, r_out_pay.by, r_out_pay.bx,
                              r_out_pay.aoy, r_out_pay.aox, r_out_pay.ay, r_out_pay.ax};
    assign o_m_axis_tuser  = r_out_oc;

    // an accepted item shows up in stage 0
    a_accept_s0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_s0_valid)
        else $error("accepted item missing in stage 0");

    // contact implies a nonzero root operand
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq_valid[0] && r_sq_pay[0].hit) |-> (r_sq_v[0] != '0))
        else $error("contact with zero distance");

    // unit normal never exceeds one
    a_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_valid[QW] && r_dv_pay[QW].hit) |->
        (r_dv_qx[QW] <= QW'(ELAST_ONE) && r_dv_qy[QW] <= QW'(ELAST_ONE)))
        else $error("normal component above one");

    // a stall freezes the pipeline
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_p7_valid) && $stable(r_dv_valid[QW])))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

@@ verif/bpcr_checker.sv @@
`default_nettype none

module bpcr_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_valid,
    input  wire                         i_s_ready,
    input  wire  [bpcr_pkg::IN_DW-1:0]  i_s_data,
    input  wire                         i_m_valid,
    input  wire                         i_m_ready,
    input  wire  [bpcr_pkg::OUT_DW-1:0] i_m_data,
    input  wire  [1:0]                  i_m_user,
    input  wire                         i_cfg_we,
    input  wire  [bpcr_pkg::EW-1:0]     i_cfg_wdata,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_hits_sep,
    output int                          o_hits_res
);
    import bpcr_pkg::*;

    typedef struct {
        logic [OUT_DW-1:0] coords;
        t_outcome          kind;
    } t_resolved;

    t_resolved resolved_q[$];
    logic [EW-1:0] elast;

    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    function automatic longint clamp_coord(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint round_shr(longint v, int s);
        longint m;
        m = ((v < 0 ? -v : v) + (64'sd1 <<< (s - 1))) >>> s;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint int_root(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint unit_axis(longint d, longint root_len);
        longint q;
        q = (((d < 0 ? -d : d) <<< (NB + XB)) + (root_len >>> 1)) / root_len;
        return d < 0 ? -q : q;
    endfunction

    function automatic t_resolved resolve_pair(logic [IN_DW-1:0] p, logic [EW-1:0] e);
        longint c[8];
        longint ra, rb, md, dx, dy, d2, root_len, nx, ny, ov, cx, cy;
        longint rvx, rvy, s, v, j, ix, iy;
        t_resolved r;
        int k;
        c[0] = longint'($signed(p[0*CW +: CW]));
        c[1] = longint'($signed(p[1*CW +: CW]));
        c[2] = longint'($signed(p[2*CW +: CW]));
        c[3] = longint'($signed(p[3*CW +: CW]));
        ra   = longint'(p[4*CW +: RW]);
        c[4] = longint'($signed(p[4*CW+RW +: CW]));
        c[5] = longint'($signed(p[5*CW+RW +: CW]));
        c[6] = longint'($signed(p[6*CW+RW +: CW]));
        c[7] = longint'($signed(p[7*CW+RW +: CW]));
        rb   = longint'(p[8*CW+RW +: RW]);
        r.kind = OUT_NONE;
        md = ra + rb;
        dx = c[4] - c[0];
        dy = c[5] - c[1];
        if ((dx < 0 ? -dx : dx) < md && (dy < 0 ? -dy : dy) < md) begin
            d2 = dx * dx + dy * dy;
            if (d2 != 0 && d2 < md * md) begin
                root_len = int_root(d2 <<< (2 * XB));
                nx = unit_axis(dx, root_len);
                ny = unit_axis(dy, root_len);
                ov = (md <<< XB) - root_len;
                cx = round_shr(ov * nx, NB + XB + 1);
                cy = round_shr(ov * ny, NB + XB + 1);
                c[0] = clamp_coord(c[0] - cx);
                c[1] = clamp_coord(c[1] - cy);
                c[4] = clamp_coord(c[4] + cx);
                c[5] = clamp_coord(c[5] + cy);
                rvx = (c[4] - c[6]) - (c[0] - c[2]);
                rvy = (c[5] - c[7]) - (c[1] - c[3]);
                s = rvx * nx + rvy * ny;
                if (s > 0) begin
                    r.kind = OUT_SEP;
                end else begin
                    v = round_shr(s, NB);
                    j = round_shr(-v * (64'sd65536 + longint'(e)), 17);
                    ix = round_shr(j * nx, NB);
                    iy = round_shr(j * ny, NB);
                    c[2] = clamp_coord(c[2] + ix);
                    c[3] = clamp_coord(c[3] + iy);
                    c[6] = clamp_coord(c[6] - ix);
                    c[7] = clamp_coord(c[7] - iy);
                    r.kind = OUT_RES;
                end
            end
        end
        for (k = 0; k < 8; k++) r.coords[k*CW +: CW] = c[k][CW-1:0];
        return r;
    endfunction

    assign o_pending = resolved_q.size();

    always @(posedge i_clk) begin
        t_resolved want;
        int k;
        if (!i_rst_n) begin
            elast <= ELAST_RST;
            o_errors <= 0;
            o_hits_sep <= 0;
            o_hits_res <= 0;
        end else begin
            if (i_cfg_we) elast <= i_cfg_wdata;
            if (i_s_valid && i_s_ready) resolved_q = {resolved_q, resolve_pair(i_s_data, elast)};
            if (i_m_valid && i_m_ready) begin
                if (resolved_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h", i_m_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = resolved_q.pop_front();
                    if (want.kind == OUT_SEP) o_hits_sep <= o_hits_sep + 1;
                    if (want.kind == OUT_RES) o_hits_res <= o_hits_res + 1;
                    if (want.coords != i_m_data || want.kind != i_m_user) begin
                        if (o_errors < 10) begin
                            for (k = 0; k < 8; k++)
                                if (want.coords[k*CW +: CW] != i_m_data[k*CW +: CW])
                                    $display("coord %0d: expected %h got %h", k,
                                             want.coords[k*CW +: CW], i_m_data[k*CW +: CW]);
                            if (want.kind != i_m_user)
                                $display("outcome: expected %0d got %0d", want.kind, i_m_user);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

@@ verif/tb_ball_pair_collision_response_core.sv @@
`default_nettype none

module tb_ball_pair_collision_response_core;
    import bpcr_pkg::*;

    localparam int LATENCY = 55;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    wire                  s_ready;
    logic [IN_DW-1:0]     s_data = '0;
    wire                  m_valid;
    logic                 m_ready = 1'b0;
    wire  [OUT_DW-1:0]    m_data;
    wire  [1:0]           m_user;
    logic                 cfg_we = 1'b0;
    logic [EW-1:0]        cfg_wdata = '0;

    int errors, pending, hits_sep, hits_res;
    // idle percentages for sender and receiver, set per phase
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_recv = 1'b0;
    int items_sent = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ball_pair_collision_response_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    bpcr_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_valid),
        .i_s_ready   (s_ready),
        .i_s_data    (s_data),
        .i_m_valid   (m_valid),
        .i_m_ready   (m_ready),
        .i_m_data    (m_data),
        .i_m_user    (m_user),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_hits_sep  (hits_sep),
        .o_hits_res  (hits_res)
    );

    // receiver: random stall per cycle, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) m_ready <= 1'b0;
        else m_ready <= !hold_recv && ($urandom_range(99) >= recv_stall);
    end

    // pack one circle pair, first field in the lowest bits
    function automatic logic [IN_DW-1:0] pack_pair(
        logic [CW-1:0] ax, ay, aox, aoy, logic [RW-1:0] ra,
        logic [CW-1:0] bx, by, box, boy, logic [RW-1:0] rb);
        return {rb, boy, box, by, bx, ra, aoy, aox, ay, ax};
    endfunction

    // send one item: optional idle gap, then hold valid until accepted
    task automatic offer_pair(logic [IN_DW-1:0] p);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // pipeline must be empty before touching elasticity
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic set_elasticity(logic [EW-1:0] e);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= e;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // signed delta drawn uniformly from -span to +span
    function automatic logic [CW-1:0] jitter(logic [CW-1:0] base, int span);
        return base + CW'($signed($urandom_range(2 * span) - span));
    endfunction

    // mostly overlapping pairs with random velocities, some noise
    function automatic logic [IN_DW-1:0] random_pair();
        logic [CW-1:0] ax, ay, bx, by;
        logic [RW-1:0] ra, rb;
        int sel, span;
        sel = $urandom_range(99);
        if (sel < 10) begin
            return IN_DW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom});
        end
        span = (sel < 80) ? 32'h4000 : 32'h0F_FFFF;
        ra = RW'($urandom_range(span));
        rb = RW'($urandom_range(span));
        ax = (sel > 94) ? CW'(32'h7F_F000 + $urandom_range(4095)) : CW'($urandom);
        ay = (sel > 96) ? CW'(32'h80_0000 + $urandom_range(4095)) : CW'($urandom);
        bx = jitter(ax, int'(ra) + int'(rb) + 1);
        by = jitter(ay, int'(ra) + int'(rb) + 1);
        return pack_pair(ax, ay, jitter(ax, 2000), jitter(ay, 2000), ra,
                         bx, by, jitter(bx, 2000), jitter(by, 2000), rb);
    endfunction

    task automatic random_phase(int count, int s_idle, int r_stall);
        send_idle  = s_idle;
        recv_stall = r_stall;
        repeat (count) offer_pair(random_pair());
        send_idle  = 0;
        recv_stall = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: coincident centres, exact touch, head-on, separating,
        // zero normal velocity, saturation at both rails, extreme radii
        offer_pair(pack_pair(24'h001000, 24'h002000, 24'h001000, 24'h002000, 20'h01000,
                             24'h001000, 24'h002000, 24'h001000, 24'h002000, 20'h01000));
        offer_pair(pack_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 20'h01000,
                             24'h002000, 24'h000000, 24'h002000, 24'h000000, 20'h01000));
        offer_pair(pack_pair(24'h000000, 24'h000000, 24'hFFFF00, 24'h000000, 20'h01000,
                             24'h001800, 24'h000000, 24'h001900, 24'h000000, 20'h01000));
        offer_pair(pack_pair(24'h000000, 24'h000000, 24'h000100, 24'h000000, 20'h01000,
                             24'h001800, 24'h000000, 24'h001700, 24'h000000, 20'h01000));
        offer_pair(pack_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 20'h01000,
                             24'h000800, 24'h000800, 24'h000800, 24'h000800, 20'h01000));
        offer_pair(pack_pair(24'h7FFF00, 24'h7FFF00, 24'h800000, 24'h800000, 20'hFFFFF,
                             24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 20'hFFFFF));
        offer_pair(pack_pair(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 20'hFFFFF,
                             24'h800100, 24'h800001, 24'h7FFFFF, 24'h7FFFFF, 20'hFFFFF));
        offer_pair(pack_pair(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 20'hFFFFF,
                             24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 20'h00000));
        offer_pair(pack_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 20'h00000,
                             24'h000001, 24'h000000, 24'h000000, 24'h000000, 20'h00000));
        offer_pair(pack_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 20'h00001,
                             24'h000001, 24'h000000, 24'h000001, 24'h000000, 20'h00001));
        offer_pair('1);
        offer_pair('0);
        repeat (8) offer_pair(random_pair());

        // elasticity corners, with random traffic at each
        set_elasticity(EW'(0));
        random_phase(250, 0, 0);
        set_elasticity(EW'(ELAST_ONE));
        random_phase(250, 82, 0);
        set_elasticity(EW'(17'h1FFFF));
        random_phase(250, 0, 82);
        set_elasticity(EW'(32768));
        random_phase(250, 20, 20);
        set_elasticity(EW'($urandom_range(ELAST_ONE)));
        random_phase(300, 0, 0);

        // long receiver hold-off while the sender keeps pushing
        fork
            begin
                hold_recv = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            random_phase(200, 0, 0);
        join

        set_elasticity(ELAST_RST);
        random_phase(330, 0, 0);

        drain_block();
        $display("sent %0d circle pairs over several elasticity settings", items_sent);
        $display("separated only: %0d, impulse resolved: %0d", hits_sep, hits_res);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

@@ files.f @@
design/bpcr_pkg.sv
design/ball_pair_collision_response_core.sv
verif/bpcr_checker.sv
verif/tb_ball_pair_collision_response_core.sv
